FILE: design/bsd_pkg.sv
// shared types, constants and helpers of the bunch sample stream decoder
package bsd_pkg;

  // trailer check patterns and fill word
  localparam logic [13:0] TRAILER_MARK   = 14'h2AAA;
  localparam logic [3:0]  TRAILER_NIBBLE = 4'hA;
  localparam logic [9:0]  FILL_WORD      = 10'h2AA;
  localparam logic [9:0]  MIN_BUNCH_LEN  = 10'd3;

  // configuration register index, taken from paddr[2]
  localparam logic REG_IDX_VERIFY = 1'b0;

  // error codes carried in a result
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MARKER    = 3'd1,
    ERR_NIBBLE    = 3'd2,
    ERR_FILL      = 3'd3,
    ERR_MALFORMED = 3'd4
  } err_code_t;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_TRAILER = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_TIME    = 4'b0100,
    PH_SAMPLE  = 4'b1000
  } phase_t;

  // one result without the address and last flag
  typedef struct packed {
    logic       is_error;
    logic [9:0] time_bin;
    logic [9:0] sample_value;
    err_code_t  error_code;
  } result_t;

  // all results of one input word
  typedef struct packed {
    logic [11:0]      address;
    logic [2:0]       count;
    result_t [3:0]    res;
  } bundle_t;

  function automatic result_t mk_result(input logic is_err, input logic [9:0] tb,
                                        input logic [9:0] val, input err_code_t code);
    result_t r;
    r.is_error     = is_err;
    r.time_bin     = tb;
    r.sample_value = val;
    r.error_code   = code;
    return r;
  endfunction

endpackage

FILE: design/bsd_if.sv
// stream interfaces for input words and result beats
interface bsd_in_if;
  logic        valid;
  logic        ready;
  logic [39:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic        is_error;
  logic [11:0] channel_address;
  logic [9:0]  time_bin;
  logic [9:0]  sample_value;
  logic [2:0]  error_code;
  logic        last_of_item;

  modport source (output valid, output is_error, output channel_address, output time_bin,
                  output sample_value, output error_code, output last_of_item, input ready);
  modport sink (input valid, input is_error, input channel_address, input time_bin,
                input sample_value, input error_code, input last_of_item, output ready);
endinterface

FILE: design/bunch_sample_stream_decoder.sv
// top level: register port, front parser, bundle queue and result sequencer
// path: an accepted word's bundle is registered in the queue, then in the sequencer
// throughput: one input beat per cycle while the queue is not full; result beats leave
//   one per cycle, while out_ch.ready is high, through the single result port
// reset: synchronous rst clears the parse state, halt flag, verify flag, queue and
//   result sequencer; an error halts the parser, which drops every word until reset
module bunch_sample_stream_decoder import bsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bsd_in_if.sink      in_ch,
  bsd_out_if.source   out_ch
);

  logic    verify;
  logic    push;
  bundle_t push_data;
  logic    q_full;
  logic    pop;
  logic    q_valid;
  bundle_t q_data;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_VERIFY) ? {31'd0, verify} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      verify <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_VERIFY) begin
      verify <= pwdata[0];
    end
  end

  bsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .verify    (verify),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  bsd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("bundle queue written while full");

  // an error beat always closes its word
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_error) |-> out_ch.last_of_item)
    else $error("error beat not last of its word");

  // error flag and error code agree
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.is_error == (out_ch.error_code != ERR_NONE)))
    else $error("error flag and code disagree");

  // a held result beat keeps its place while stalled
  a_beat_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.sample_value)
      && $stable(out_ch.last_of_item)))
    else $error("stalled result beat changed");

endmodule

FILE: design/bsd_front.sv
// front part: accepts words, runs the parse state and builds result bundles
module bsd_front import bsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        verify,
  bsd_in_if.sink      in_ch,
  input  logic        q_full,
  output logic        push,
  output bundle_t     push_data
);

  phase_t      phase, phase_next;
  logic [9:0]  words_left, words_left_next;
  logic [1:0]  fill_left, fill_left_next;
  logic [9:0]  bunch_left, bunch_left_next;
  logic [9:0]  cur_time, cur_time_next;
  logic [11:0] cur_addr, cur_addr_next;
  logic        halted, halted_next;
  logic        fire;
  logic [39:0] w;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign w           = in_ch.data_word;

  // parse one word: trailer decode or four slots in order
  always_comb begin
    phase_t     ph;
    logic [9:0] wlv;
    logic [1:0] flv;
    logic [9:0] blv;
    logic [9:0] ctv;
    logic [9:0] v;
    logic [2:0] n;
    logic       go;
    bundle_t    bun;

    phase_next      = phase;
    words_left_next = words_left;
    fill_left_next  = fill_left;
    bunch_left_next = bunch_left;
    cur_time_next   = cur_time;
    cur_addr_next   = cur_addr;
    halted_next     = halted;
    ph  = phase;
    wlv = words_left;
    flv = fill_left;
    blv = bunch_left;
    ctv = cur_time;
    v   = '0;
    n   = 3'd0;
    go  = 1'b1;
    bun = '0;
    bun.address = cur_addr;

    if (fire && !halted) begin
      if (phase == PH_TRAILER) begin
        cur_addr_next = w[11:0];
        bun.address   = w[11:0];
        if (verify && w[39:26] != TRAILER_MARK) begin
          bun.res[0]  = mk_result(1'b1, 10'd0, 10'd0, ERR_MARKER);
          n           = 3'd1;
          halted_next = 1'b1;
        end else if (verify && w[15:12] != TRAILER_NIBBLE) begin
          bun.res[0]  = mk_result(1'b1, 10'd0, 10'd0, ERR_NIBBLE);
          n           = 3'd1;
          halted_next = 1'b1;
        end else begin
          words_left_next = w[25:16];
          fill_left_next  = 2'd0 - w[17:16];
          bunch_left_next = '0;
          phase_next      = (w[25:16] == 10'd0) ? PH_TRAILER : PH_LENGTH;
        end
      end else begin
        for (int s = 0; s < 4; s++) begin
          v = w[39 - 10*s -: 10];
          if (go && ph != PH_TRAILER) begin
            if (flv != 2'd0) begin
              // leading fill word
              if (verify && v != FILL_WORD) begin
                bun.res[n[1:0]] = mk_result(1'b1, 10'd0, v, ERR_FILL);
                n           = n + 3'd1;
                halted_next = 1'b1;
                go          = 1'b0;
              end else begin
                flv = flv - 2'd1;
              end
            end else begin
              case (ph)
                PH_LENGTH: begin
                  if (v < MIN_BUNCH_LEN || v > wlv) begin
                    bun.res[n[1:0]] = mk_result(1'b1, 10'd0, v, ERR_MALFORMED);
                    n           = n + 3'd1;
                    halted_next = 1'b1;
                    go          = 1'b0;
                  end else begin
                    blv = v - 10'd2;
                    ph  = PH_TIME;
                  end
                end
                PH_TIME: begin
                  ctv = v;
                  ph  = PH_SAMPLE;
                end
                PH_SAMPLE: begin
                  bun.res[n[1:0]] = mk_result(1'b0, ctv, v, ERR_NONE);
                  n   = n + 3'd1;
                  ctv = ctv - 10'd1;
                  blv = blv - 10'd1;
                  if (blv == 10'd0) ph = PH_LENGTH;
                end
                default: begin
                  ph = PH_TRAILER;
                end
              endcase
              // count the word against the channel
              if (go) begin
                wlv = wlv - 10'd1;
                if (wlv == 10'd0 && ph == PH_LENGTH) ph = PH_TRAILER;
              end
            end
          end
        end
        phase_next      = ph;
        words_left_next = wlv;
        fill_left_next  = flv;
        bunch_left_next = blv;
        cur_time_next   = ctv;
      end
    end

    bun.count = n;
    push      = (n != 3'd0);
    push_data = bun;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TRAILER;
      words_left <= '0;
      fill_left  <= '0;
      bunch_left <= '0;
      cur_time   <= '0;
      cur_addr   <= '0;
      halted     <= 1'b0;
    end else begin
      phase      <= phase_next;
      words_left <= words_left_next;
      fill_left  <= fill_left_next;
      bunch_left <= bunch_left_next;
      cur_time   <= cur_time_next;
      cur_addr   <= cur_addr_next;
      halted     <= halted_next;
    end
  end

endmodule

FILE: design/bsd_queue.sv
// two-entry bundle queue between front and back
module bsd_queue import bsd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output bundle_t pop_data
);

  bundle_t    slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = slots[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/bsd_back.sv
// back part: plays out a bundle one result beat per cycle while out_ch.ready is high
module bsd_back import bsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  bundle_t  q_data,
  output logic     pop,
  bsd_out_if.source out_ch
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;
  logic       fire;
  result_t    r;

  assign r    = cur.res[idx];
  assign last = ({1'b0, idx} == cur.count - 3'd1);
  assign fire = out_ch.valid && out_ch.ready;
  assign pop  = q_valid && (!cur_valid || (fire && last));

  // result beat fields
  assign out_ch.valid           = cur_valid;
  assign out_ch.is_error        = r.is_error;
  assign out_ch.channel_address = cur.address;
  assign out_ch.time_bin        = r.time_bin;
  assign out_ch.sample_value    = r.sample_value;
  assign out_ch.error_code      = r.error_code;
  assign out_ch.last_of_item    = last;

  // bundle payload
  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
  end

  // slot sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fire) begin
      if (last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

FILE: dv/tb_bunch_sample_stream_decoder.sv
// self-checking testbench for the bunch sample stream decoder
module tb_bunch_sample_stream_decoder;
  import bsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // trailer and fill patterns checked when verify is on
  localparam logic [13:0] MARK_PATTERN   = 14'h2AAA;
  localparam logic [3:0]  NIBBLE_PATTERN = 4'hA;
  localparam logic [9:0]  FILL_PATTERN   = 10'h2AA;
  localparam logic [2:0]  VERIFY_ADDR    = 3'd0;

  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 4;
  localparam int BIG_AFTER    = 40;
  localparam int QUIET_FROM   = 380;
  localparam int RANDOM_END   = 440;
  localparam int PRINT_CAP    = 40;

  // ways of breaking the stream at the end of the run
  typedef enum int {
    BREAK_MARKER,
    BREAK_NIBBLE,
    BREAK_FILL,
    BREAK_SHORT,
    BREAK_LONG
  } break_kind_t;

  typedef struct {
    logic        is_error;
    logic [11:0] channel_address;
    logic [9:0]  time_bin;
    logic [9:0]  sample_value;
    err_code_t   error_code;
    logic        last_of_item;
  } result_beat_t;

  // predicts result beats from accepted words and checks the ones that come out
  class sample_scoreboard;
    bit          verify;
    phase_t      phase;
    logic [9:0]  words_left;
    logic [9:0]  bunch_left;
    logic [9:0]  cur_time;
    logic [1:0]  fill_left;
    logic [11:0] cur_addr;
    bit          halted;
    result_beat_t expected_beats[$];
    int          mismatches;
    int          beats_seen;

    function new();
      clear();
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function void clear();
      verify = 1'b0;
      phase = PH_TRAILER;
      words_left = '0;
      bunch_left = '0;
      cur_time = '0;
      fill_left = '0;
      cur_addr = '0;
      halted = 1'b0;
      expected_beats.delete();
    endfunction

    function result_beat_t make_beat(logic err, logic [9:0] tb, logic [9:0] val,
                                     err_code_t code);
      result_beat_t b;
      b.is_error = err;
      b.channel_address = cur_addr;
      b.time_bin = tb;
      b.sample_value = val;
      b.error_code = code;
      b.last_of_item = 1'b0;
      return b;
    endfunction

    function void note_word(logic [39:0] w);
      result_beat_t beats[4];
      logic [9:0] v;
      logic [9:0] cnt;
      int n;
      int s;
      n = 0;
      if (halted) return;
      if (phase == PH_TRAILER) begin
        // trailer: address always taken, then marker and nibble checks
        cur_addr = w[11:0];
        if (verify && w[39:26] != MARK_PATTERN) begin
          beats[n] = make_beat(1'b1, '0, '0, ERR_MARKER);
          n++;
          halted = 1'b1;
        end else if (verify && w[15:12] != NIBBLE_PATTERN) begin
          beats[n] = make_beat(1'b1, '0, '0, ERR_NIBBLE);
          n++;
          halted = 1'b1;
        end else begin
          cnt = w[25:16];
          words_left = cnt;
          fill_left = 2'd0 - cnt[1:0];
          bunch_left = '0;
          phase = (cnt == 0) ? PH_TRAILER : PH_LENGTH;
        end
      end else begin
        // data word: four 10-bit words, high bits first
        for (s = 0; s < 4; s++) begin
          if (halted || phase == PH_TRAILER) break;
          v = w[39-10*s -: 10];
          if (fill_left != 0) begin
            if (verify && v != FILL_PATTERN) begin
              beats[n] = make_beat(1'b1, '0, v, ERR_FILL);
              n++;
              halted = 1'b1;
            end else begin
              fill_left--;
            end
          end else begin
            case (phase)
              PH_LENGTH: begin
                if (v < 10'd3 || v > words_left) begin
                  beats[n] = make_beat(1'b1, '0, v, ERR_MALFORMED);
                  n++;
                  halted = 1'b1;
                end else begin
                  bunch_left = v - 10'd2;
                  phase = PH_TIME;
                end
              end
              PH_TIME: begin
                cur_time = v;
                phase = PH_SAMPLE;
              end
              default: begin
                beats[n] = make_beat(1'b0, cur_time, v, ERR_NONE);
                n++;
                cur_time--;
                bunch_left--;
                if (bunch_left == 0) phase = PH_LENGTH;
              end
            endcase
            if (!halted) begin
              words_left--;
              if (words_left == 0 && phase == PH_LENGTH) phase = PH_TRAILER;
            end
          end
        end
      end
      if (n > 0) beats[n-1].last_of_item = 1'b1;
      for (s = 0; s < n; s++) expected_beats.push_back(beats[s]);
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [11:0] got, logic [11:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s got %0h expected %0h", beats_seen, name, got, want));
    endtask

    task check_beat(result_beat_t got);
      result_beat_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected", beats_seen));
        return;
      end
      want = expected_beats.pop_front();
      check_field("is_error", got.is_error, want.is_error);
      check_field("channel_address", got.channel_address, want.channel_address);
      check_field("time_bin", got.time_bin, want.time_bin);
      check_field("sample_value", got.sample_value, want.sample_value);
      check_field("error_code", got.error_code, want.error_code);
      check_field("last_of_item", got.last_of_item, want.last_of_item);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bsd_in_if  in_ch ();
  bsd_out_if out_ch ();

  bunch_sample_stream_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  sample_scoreboard model = new();
  logic [39:0] word_stream[$];
  logic [9:0]  tenbit_buf[$];
  int          words_accepted = 0;
  int          quiet_cycles = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // input beat monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      model.note_word(in_ch.data_word);
      words_accepted++;
    end
  end

  // result beat monitor
  always @(posedge clk) begin
    result_beat_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.is_error = out_ch.is_error;
      got.channel_address = out_ch.channel_address;
      got.time_bin = out_ch.time_bin;
      got.sample_value = out_ch.sample_value;
      got.error_code = err_code_t'(out_ch.error_code);
      got.last_of_item = out_ch.last_of_item;
      model.check_beat(got);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[bunch_sample_stream_decoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver: random stalls and one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_en && $urandom_range(7, 0) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // register write: setup then access phase
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == VERIFY_ADDR) model.verify = data[0];
  endtask

  // offer queued words, with random gaps between beats
  task automatic send_words(input int how_many);
    int k;
    k = 0;
    while (word_stream.size() != 0 && k < how_many) begin
      if (idle_en && $urandom_range(3, 0) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.data_word <= word_stream.pop_front();
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      k++;
    end
    in_ch.valid <= 1'b0;
  endtask

  // wait for every expected beat, then let the pipeline settle
  task automatic wait_results_done();
    @(posedge clk);
    while (model.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [39:0] trailer_word(int cnt, bit ver);
    logic [13:0] mark;
    logic [3:0]  nib;
    mark = (ver || $urandom_range(1, 0)) ? MARK_PATTERN : 14'($urandom);
    nib = (ver || $urandom_range(1, 0)) ? NIBBLE_PATTERN : 4'($urandom);
    return {mark, 10'(cnt), nib, 12'($urandom)};
  endfunction

  // pack buffered 10-bit words into data words, padding the tail at random
  function automatic void flush_tenbits();
    logic [39:0] w;
    int s;
    while (tenbit_buf.size() % 4 != 0) tenbit_buf.push_back(10'($urandom));
    while (tenbit_buf.size() != 0) begin
      w = '0;
      for (s = 0; s < 4; s++) w[39-10*s -: 10] = tenbit_buf.pop_front();
      word_stream.push_back(w);
    end
  endfunction

  function automatic void add_bunch(int len);
    tenbit_buf.push_back(10'(len));
    tenbit_buf.push_back(($urandom_range(3, 0) == 0) ? 10'd0 : 10'($urandom));
    repeat (len - 2) tenbit_buf.push_back(10'($urandom));
  endfunction

  // bunch length that never leaves one or two words over
  function automatic int pick_len(int rem, int max_len);
    int hi;
    int len;
    if (rem <= max_len && $urandom_range(3, 0) == 0) return rem;
    hi = (rem < max_len) ? rem : max_len;
    len = $urandom_range(hi, 3);
    if (rem - len == 1 || rem - len == 2) len = rem;
    return len;
  endfunction

  function automatic void add_channel(int cnt, int max_len, bit ver);
    int rem;
    int len;
    word_stream.push_back(trailer_word(cnt, ver));
    repeat ((4 - cnt % 4) % 4) tenbit_buf.push_back(ver ? FILL_PATTERN : 10'($urandom));
    rem = cnt;
    while (rem > 0) begin
      len = pick_len(rem, max_len);
      add_bunch(len);
      rem -= len;
    end
    flush_tenbits();
  endfunction

  // one faulty item that halts the block, then words it must drop
  function automatic void add_broken_tail(break_kind_t kind, bit ver);
    logic [13:0] bad_mark;
    logic [3:0]  bad_nib;
    logic [9:0]  bad_fill;
    int cnt;
    int pad;
    int bad_at;
    int rem;
    int len;
    int i;
    bad_mark = 14'($urandom);
    if (bad_mark == MARK_PATTERN) bad_mark ^= 14'h1;
    bad_nib = 4'($urandom);
    if (bad_nib == NIBBLE_PATTERN) bad_nib ^= 4'h1;
    bad_fill = 10'($urandom);
    if (bad_fill == FILL_PATTERN) bad_fill ^= 10'h1;
    case (kind)
      BREAK_MARKER: begin
        word_stream.push_back({bad_mark, 10'($urandom), 4'($urandom), 12'($urandom)});
      end
      BREAK_NIBBLE: begin
        word_stream.push_back({MARK_PATTERN, 10'($urandom), bad_nib, 12'($urandom)});
      end
      BREAK_FILL: begin
        cnt = 4 * $urandom_range(4, 1) + $urandom_range(3, 1);
        pad = (4 - cnt % 4) % 4;
        bad_at = $urandom_range(pad - 1, 0);
        word_stream.push_back(trailer_word(cnt, 1'b1));
        for (i = 0; i < pad; i++) tenbit_buf.push_back((i == bad_at) ? bad_fill : FILL_PATTERN);
        flush_tenbits();
      end
      default: begin
        cnt = $urandom_range(40, 6);
        word_stream.push_back(trailer_word(cnt, ver));
        repeat ((4 - cnt % 4) % 4) tenbit_buf.push_back(ver ? FILL_PATTERN : 10'($urandom));
        rem = cnt;
        if ($urandom_range(1, 0)) begin
          len = $urandom_range(cnt - 1, 3);
          add_bunch(len);
          rem -= len;
        end
        if (kind == BREAK_SHORT) tenbit_buf.push_back(10'($urandom_range(2, 0)));
        else tenbit_buf.push_back(10'($urandom_range(1023, rem + 1)));
        flush_tenbits();
      end
    endcase
    repeat (4) word_stream.push_back(40'($urandom) << 8 | 40'($urandom_range(255, 0)));
  endfunction

  // main sequence
  initial begin
    int phase_idx;
    int first;
    bit ver;
    bit big_done;
    break_kind_t kind;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_word <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty channels at the address extremes
    word_stream.push_back(40'h0);
    word_stream.push_back({14'h3FFF, 10'd0, 4'hF, 12'hFFF});
    // single-sample bunch behind an all-ones fill word
    word_stream.push_back({14'h3FFF, 10'd3, 4'hF, 12'hFFF});
    word_stream.push_back({10'h3FF, 10'd3, 10'd0, 10'h3FF});
    // two bunches, time bins wrap below zero
    word_stream.push_back({14'h0, 10'd8, 4'h0, 12'h800});
    word_stream.push_back({10'd4, 10'd0, 10'h3FF, 10'h000});
    word_stream.push_back({10'd4, 10'h3FF, 10'h2AA, 10'h155});
    send_words(word_stream.size());
    wait_results_done();

    // checked channel, verify dropped in the middle of it
    write_reg(VERIFY_ADDR, 32'd1);
    word_stream.push_back({MARK_PATTERN, 10'd6, NIBBLE_PATTERN, 12'h5A5});
    word_stream.push_back({FILL_PATTERN, FILL_PATTERN, 10'd6, 10'd2});
    word_stream.push_back({10'h001, 10'h3FE, 10'h200, 10'h1FF});
    send_words(2);
    wait_results_done();
    write_reg(VERIFY_ADDR, 32'd0);
    send_words(word_stream.size());
    wait_results_done();

    // checked channel with three fill words
    write_reg(VERIFY_ADDR, 32'd1);
    add_channel(5, 5, 1'b1);
    send_words(word_stream.size());
    wait_results_done();

    // random channels, one of full size under a long result hold-off
    phase_idx = 0;
    big_done = 1'b0;
    while (words_accepted < RANDOM_END) begin
      idle_en = (words_accepted < QUIET_FROM) && ($urandom_range(3, 0) != 0);
      ver = (phase_idx % 3 != 0);
      if (!big_done && words_accepted >= BIG_AFTER) begin
        ver = 1'b0;
        first = word_stream.size();
        add_channel(1023, 1023, 1'b0);
        word_stream[first] = '1;
        big_done = 1'b1;
        hold_req = 1'b1;
      end else begin
        repeat ($urandom_range(5, 1))
          add_channel(($urandom_range(7, 0) == 0) ? 0 : $urandom_range(40, 3),
                      $urandom_range(16, 3), ver);
      end
      write_reg(VERIFY_ADDR, {31'd0, ver});
      send_words(word_stream.size());
      wait_results_done();
      phase_idx++;
    end

    // one fault at the end halts the block for good
    idle_en = 1'b0;
    kind = break_kind_t'($urandom_range(4, 0));
    ver = (kind == BREAK_MARKER || kind == BREAK_NIBBLE || kind == BREAK_FILL) ?
          1'b1 : 1'($urandom_range(1, 0));
    write_reg(VERIFY_ADDR, {31'd0, ver});
    add_broken_tail(kind, ver);
    send_words(word_stream.size());
    wait_results_done();
    repeat (16) @(posedge clk);

    if (model.mismatches == 0) begin
      $display("[bunch_sample_stream_decoder] OK");
    end else begin
      $display("[bunch_sample_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

FILE: bunch_sample_stream_decoder.f
design/bsd_pkg.sv
design/bsd_if.sv
design/bsd_front.sv
design/bsd_queue.sv
design/bsd_back.sv
design/bunch_sample_stream_decoder.sv
dv/tb_bunch_sample_stream_decoder.sv
